### hdl/network_address_classifier_core_defines.svh
// ----------------------------------------------------------------------------
// Address classifier assertion macros
// Property wrappers used by the classifier RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef NETWORK_ADDRESS_CLASSIFIER_CORE_DEFINES_SVH
`define NETWORK_ADDRESS_CLASSIFIER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define NAC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nac assertion failed");

// delayed implication
`define NAC_ASSERT_LAT3(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##3 (cons)) \
      else $error("nac latency assertion failed");

`else

`define NAC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define NAC_ASSERT_LAT3(label, clk, rst, ante, cons)

`endif

`endif

### hdl/nac_pkg.sv
// ----------------------------------------------------------------------------
// Address classifier package
// Kind and class codes, range constants and inter-stage structs.
// ----------------------------------------------------------------------------
package nac_pkg;

   typedef enum logic [1:0] {
      KIND_IPV4   = 2'd0,
      KIND_IPV6   = 2'd1,
      KIND_ONION  = 2'd2,
      KIND_GARLIC = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      CLASS_UNROUTABLE = 3'd0,
      CLASS_IPV4       = 3'd1,
      CLASS_IPV6       = 3'd2,
      CLASS_ONION      = 3'd3,
      CLASS_GARLIC     = 3'd4,
      CLASS_TEREDO     = 3'd5
   } class_type;

   localparam logic [7:0]  MESH_BYTE      = 8'hFC;
   localparam logic [7:0]  ULA_MASK       = 8'hFE;
   localparam logic [31:0] MAPPED_TAG     = 32'h0000_FFFF;
   localparam logic [31:0] DOC_PREFIX     = 32'h2001_0DB8;
   localparam logic [31:0] TEREDO_PREFIX  = 32'h2001_0000;
   localparam logic [27:0] ORCHID_PREFIX  = 28'h2001_001;
   localparam logic [63:0] LINK_LOCAL_HI  = 64'hFE80_0000_0000_0000;
   localparam logic [7:0]  OCT_ALL_ONES   = 8'hFF;
   localparam logic [3:0]  V4_RESV_NIBBLE = 4'hF;   // 240/4
   localparam logic [7:0]  V4_PRIV_A      = 8'd10;
   localparam logic [7:0]  V4_PRIV_B      = 8'd172;
   localparam logic [3:0]  V4_PRIV_B_HI   = 4'h1;   // second octet 16..31
   localparam logic [7:0]  V4_PRIV_C      = 8'd192;
   localparam logic [7:0]  V4_PRIV_C2     = 8'd168;
   localparam logic [7:0]  V4_LINK        = 8'd169;
   localparam logic [7:0]  V4_LINK2       = 8'd254;
   localparam logic [7:0]  V4_LOOPBACK    = 8'd127;

   // decode stage result
   typedef struct packed {
      logic        is4;
      logic        is6;
      logic        mesh;
      logic        mapped;
      logic        onion;
      logic        garlic;
      logic [31:0] v4;
      logic        shifted;    // bytes 0..6 zero, bytes 7,8 all ones
      logic        all_zero;
      logic        doc;
      logic        link_local;
      logic        ula;
      logic        orchid;
      logic        loopback;
      logic        teredo;
   } dec_type;

   // check stage result
   typedef struct packed {
      logic is4;
      logic mesh;
      logic mapped;
      logic onion;
      logic garlic;
      logic valid;
      logic routable;
      logic teredo;
   } chk_type;

endpackage

### hdl/nac_decode.sv
// ----------------------------------------------------------------------------
// Address classifier decode stage
// Normalizes the address kind and registers the wide IPv6 pattern compares.
// ----------------------------------------------------------------------------
module nac_decode
   import nac_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [1:0]  addr_kind,
   input  logic [63:0] addr_high,
   input  logic [63:0] addr_low,
   output logic        dec_valid,
   output dec_type     dec
);

   logic    valid_ff;
   dec_type dec_ff;
   dec_type dec_in;

   logic hi_zero;
   logic is_v6_kind;

   assign hi_zero    = (addr_high == 64'd0);
   assign is_v6_kind = (addr_kind == KIND_IPV6);

   always_comb begin
      dec_in.mesh   = is_v6_kind && (addr_high[63:56] == MESH_BYTE);
      dec_in.mapped = is_v6_kind && !dec_in.mesh && hi_zero
                      && (addr_low[63:32] == MAPPED_TAG);
      dec_in.is4    = (addr_kind == KIND_IPV4) || dec_in.mapped;
      dec_in.is6    = is_v6_kind && !dec_in.mesh && !dec_in.mapped;
      dec_in.onion  = (addr_kind == KIND_ONION);
      dec_in.garlic = (addr_kind == KIND_GARLIC);
      dec_in.v4     = addr_low[31:0];

      dec_in.shifted    = (addr_high[63:8] == 56'd0) && (addr_high[7:0] == OCT_ALL_ONES)
                          && (addr_low[63:56] == OCT_ALL_ONES);
      dec_in.all_zero   = hi_zero && (addr_low == 64'd0);
      dec_in.doc        = (addr_high[63:32] == DOC_PREFIX);
      dec_in.link_local = (addr_high == LINK_LOCAL_HI);
      dec_in.ula        = ((addr_high[63:56] & ULA_MASK) == MESH_BYTE);
      dec_in.orchid     = (addr_high[63:36] == ORCHID_PREFIX);
      dec_in.loopback   = hi_zero && (addr_low == 64'd1);
      dec_in.teredo     = (addr_high[63:32] == TEREDO_PREFIX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      dec_ff <= dec_in;
   end

   assign dec_valid = valid_ff;
   assign dec       = dec_ff;

endmodule

### hdl/nac_check.sv
// ----------------------------------------------------------------------------
// Address classifier check stage
// Folds the decoded compares into validity and routability.
// ----------------------------------------------------------------------------
module nac_check
   import nac_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    dec_valid,
   input  dec_type dec,
   output logic    chk_valid,
   output chk_type chk
);

   logic    valid_ff;
   chk_type chk_ff;
   chk_type chk_in;

   logic [7:0] o1;
   logic [7:0] o2;
   logic       v4_bad;
   logic       v6_bad;
   logic       v4_excl;
   logic       v6_excl;

   assign o1 = dec.v4[31:24];
   assign o2 = dec.v4[23:16];

   always_comb begin
      v4_bad  = (dec.v4 == 32'hFFFF_FFFF) || (dec.v4 == 32'd0);
      v6_bad  = dec.shifted || dec.all_zero || dec.doc;
      v4_excl = (o1[7:4] == V4_RESV_NIBBLE)
                || (o1 == V4_PRIV_A)
                || ((o1 == V4_PRIV_C) && (o2 == V4_PRIV_C2))
                || ((o1 == V4_PRIV_B) && (o2[7:4] == V4_PRIV_B_HI))
                || ((o1 == V4_LINK) && (o2 == V4_LINK2))
                || (o1 == V4_LOOPBACK)
                || (o1 == 8'd0);
      v6_excl = dec.link_local || dec.ula || dec.orchid || dec.loopback;

      chk_in.is4      = dec.is4;
      chk_in.mesh     = dec.mesh;
      chk_in.mapped   = dec.mapped;
      chk_in.onion    = dec.onion;
      chk_in.garlic   = dec.garlic;
      chk_in.valid    = !((dec.is4 && v4_bad) || (dec.is6 && v6_bad));
      chk_in.routable = chk_in.valid && !((dec.is4 && v4_excl) || (dec.is6 && v6_excl));
      chk_in.teredo   = dec.is6 && dec.teredo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= dec_valid;
      end
   end

   always_ff @(posedge clock) begin
      chk_ff <= chk_in;
   end

   assign chk_valid = valid_ff;
   assign chk       = chk_ff;

endmodule

### hdl/nac_encode.sv
// ----------------------------------------------------------------------------
// Address classifier encode stage
// Picks the network class and drives the registered response.
// ----------------------------------------------------------------------------
module nac_encode
   import nac_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       chk_valid,
   input  chk_type    chk,
   output logic       rsp_valid,
   output logic [2:0] net_class,
   output logic       is_valid,
   output logic       is_routable,
   output logic       was_mapped_v4,
   output logic       is_mesh
);

   logic       valid_ff;
   logic [2:0] class_ff;
   logic [2:0] class_in;
   logic       is_valid_ff;
   logic       routable_ff;
   logic       mapped_ff;
   logic       mesh_ff;

   // Teredo wins even when unroutable
   always_comb begin
      if (chk.teredo) begin
         class_in = CLASS_TEREDO;
      end else if (!chk.routable) begin
         class_in = CLASS_UNROUTABLE;
      end else if (chk.is4) begin
         class_in = CLASS_IPV4;
      end else if (chk.onion) begin
         class_in = CLASS_ONION;
      end else if (chk.garlic) begin
         class_in = CLASS_GARLIC;
      end else begin
         class_in = CLASS_IPV6;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= chk_valid;
      end
   end

   always_ff @(posedge clock) begin
      class_ff    <= class_in;
      is_valid_ff <= chk.valid;
      routable_ff <= chk.routable;
      mapped_ff   <= chk.mapped;
      mesh_ff     <= chk.mesh;
   end

   assign rsp_valid     = valid_ff;
   assign net_class     = class_ff;
   assign is_valid      = is_valid_ff;
   assign is_routable   = routable_ff;
   assign was_mapped_v4 = mapped_ff;
   assign is_mesh       = mesh_ff;

endmodule

### hdl/network_address_classifier_core.sv
// ----------------------------------------------------------------------------
// Network address classifier core
// Usage:
//   Drive req_addr_kind, req_addr_high and req_addr_low and pulse start; the
//   request is taken at a clock edge where start is high and busy is low.
//   busy is high only while reset is held, so one request can be taken on
//   every clock cycle.
//   Each request yields one response: rsp_valid is high for one cycle with
//   the class and flags on the rsp_ ports, after the request has passed
//   through the three-stage pipeline (decode compares, validity and range
//   checks, class encode), one registered stage each; throughput is one
//   request per cycle.
//   Responses come out in request order and are not held: the receiver must
//   take each one in the cycle it is shown.
//   Reset clears the pipeline valid bits, dropping any request in flight;
//   the block keeps no other state.
// ----------------------------------------------------------------------------
`include "network_address_classifier_core_defines.svh"

module network_address_classifier_core
   import nac_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_addr_kind,
   input  logic [63:0] req_addr_high,
   input  logic [63:0] req_addr_low,
   output logic        rsp_valid,
   output logic [2:0]  rsp_net_class,
   output logic        rsp_is_valid,
   output logic        rsp_is_routable,
   output logic        rsp_was_mapped_v4,
   output logic        rsp_is_mesh
);

   logic    req_take;
   logic    dec_valid;
   dec_type dec;
   logic    chk_valid;
   chk_type chk;

   assign busy     = reset;
   assign req_take = start && !busy;

   nac_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_take),
      .addr_kind (req_addr_kind),
      .addr_high (req_addr_high),
      .addr_low  (req_addr_low),
      .dec_valid (dec_valid),
      .dec       (dec)
   );

   nac_check u_check (
      .clock     (clock),
      .reset     (reset),
      .dec_valid (dec_valid),
      .dec       (dec),
      .chk_valid (chk_valid),
      .chk       (chk)
   );

   nac_encode u_encode (
      .clock         (clock),
      .reset         (reset),
      .chk_valid     (chk_valid),
      .chk           (chk),
      .rsp_valid     (rsp_valid),
      .net_class     (rsp_net_class),
      .is_valid      (rsp_is_valid),
      .is_routable   (rsp_is_routable),
      .was_mapped_v4 (rsp_was_mapped_v4),
      .is_mesh       (rsp_is_mesh)
   );

   `NAC_ASSERT_LAT3(a_latency, clock, reset, req_take, rsp_valid)
   `NAC_ASSERT_IMPLY(a_routable_valid, clock, reset, rsp_valid && rsp_is_routable, rsp_is_valid)
   `NAC_ASSERT_IMPLY(a_mesh_class, clock, reset, rsp_valid && rsp_is_mesh, (rsp_net_class == CLASS_IPV6) && !rsp_was_mapped_v4 && rsp_is_routable)
   `NAC_ASSERT_IMPLY(a_unroutable, clock, reset, rsp_valid && (rsp_net_class == CLASS_UNROUTABLE), !rsp_is_routable)

endmodule

### sim/nac_result_checker.sv
// ----------------------------------------------------------------------------
// Address classifier result checker
// Watches the request and response ports of the classifier, predicts the
// class and flags of every accepted request, and compares each response
// against the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module nac_result_checker
   import nac_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_addr_kind,
   input  logic [63:0] req_addr_high,
   input  logic [63:0] req_addr_low,
   input  logic        rsp_valid,
   input  logic [2:0]  rsp_net_class,
   input  logic        rsp_is_valid,
   input  logic        rsp_is_routable,
   input  logic        rsp_was_mapped_v4,
   input  logic        rsp_is_mesh,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SHOWN_MISMATCHES = 10;

   typedef struct packed {
      class_type net_class;
      logic      is_valid;
      logic      is_routable;
      logic      was_mapped_v4;
      logic      is_mesh;
   } addr_result_type;

   addr_result_type expected_classes[$];

   function automatic addr_result_type classify_address(logic [1:0] kind_bits,
                                                        logic [63:0] hi, logic [63:0] lo);
      kind_type   kind;
      logic       is4, is6, mesh, mapped, valid, excluded, routable, teredo;
      logic [31:0] v4;
      logic [7:0] o1, o2;
      addr_result_type r;
      kind     = kind_type'(kind_bits);
      is4      = 1'b0;
      is6      = 1'b0;
      mesh     = 1'b0;
      mapped   = 1'b0;
      valid    = 1'b1;
      excluded = 1'b0;
      v4       = '0;
      case (kind)
         KIND_IPV4: begin
            is4 = 1'b1;
            v4  = lo[31:0];
         end
         KIND_IPV6: begin
            if (hi[63:56] == 8'hFC) begin
               mesh = 1'b1;
            end else if (hi == '0 && lo[63:32] == 32'h0000_FFFF) begin
               is4    = 1'b1;
               mapped = 1'b1;
               v4     = lo[31:0];
            end else begin
               is6 = 1'b1;
            end
         end
         default: ;
      endcase

      if (is6) begin
         // leftover of a mapped address shifted by three bytes
         if (hi[63:8] == '0 && hi[7:0] == 8'hFF && lo[63:56] == 8'hFF) valid = 1'b0;
         if (hi == '0 && lo == '0) valid = 1'b0;
         if (hi[63:32] == 32'h2001_0DB8) valid = 1'b0;
      end
      if (is4 && (v4 == '1 || v4 == '0)) valid = 1'b0;

      o1 = v4[31:24];
      o2 = v4[23:16];
      if (is4) begin
         if (o1 >= 8'd240) excluded = 1'b1;
         if (o1 == 8'd10) excluded = 1'b1;
         if (o1 == 8'd192 && o2 == 8'd168) excluded = 1'b1;
         if (o1 == 8'd172 && o2 >= 8'd16 && o2 <= 8'd31) excluded = 1'b1;
         if (o1 == 8'd169 && o2 == 8'd254) excluded = 1'b1;
         if (o1 == 8'd127 || o1 == 8'd0) excluded = 1'b1;
      end
      if (is6) begin
         if (hi == 64'hFE80_0000_0000_0000) excluded = 1'b1;
         if (hi[63:57] == 7'b1111_110) excluded = 1'b1;
         if (hi[63:36] == 28'h2001_001) excluded = 1'b1;
         if (hi == '0 && lo == 64'd1) excluded = 1'b1;
      end

      routable = valid && !excluded;
      teredo   = is6 && hi[63:32] == 32'h2001_0000;

      // Teredo wins even over an unroutable address
      if (teredo) r.net_class = CLASS_TEREDO;
      else if (!routable) r.net_class = CLASS_UNROUTABLE;
      else if (is4) r.net_class = CLASS_IPV4;
      else if (kind == KIND_ONION) r.net_class = CLASS_ONION;
      else if (kind == KIND_GARLIC) r.net_class = CLASS_GARLIC;
      else r.net_class = CLASS_IPV6;
      r.is_valid      = valid;
      r.is_routable   = routable;
      r.was_mapped_v4 = mapped;
      r.is_mesh       = mesh;
      return r;
   endfunction

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      addr_result_type got;
      addr_result_type want;
      if (!reset) begin
         if (rsp_valid !== 1'b0) begin
            got = {rsp_net_class, rsp_is_valid, rsp_is_routable, rsp_was_mapped_v4,
                   rsp_is_mesh};
            if (expected_classes.size() == 0) begin
               if (fail_count < SHOWN_MISMATCHES)
                  $display("%t: response with no request outstanding: class=%0d valid=%b",
                           $realtime, got.net_class, rsp_valid);
               fail_count = fail_count + 1;
            end else begin
               want = expected_classes.pop_front();
               if (rsp_valid !== 1'b1 || got !== want) begin
                  if (fail_count < SHOWN_MISMATCHES)
                     $display({"%t: mismatch: expected class=%0d valid=%b routable=%b ",
                               "mapped=%b mesh=%b, got class=%0d valid=%b routable=%b ",
                               "mapped=%b mesh=%b (strobe %b)"},
                              $realtime, want.net_class, want.is_valid, want.is_routable,
                              want.was_mapped_v4, want.is_mesh, got.net_class,
                              got.is_valid, got.is_routable, got.was_mapped_v4,
                              got.is_mesh, rsp_valid);
                  fail_count = fail_count + 1;
               end
            end
         end
         // append at the tail so the oldest prediction stays at the front
         if (start && !busy)
            expected_classes.insert(expected_classes.size(),
                                    classify_address(req_addr_kind, req_addr_high,
                                                     req_addr_low));
      end
      pending_count <= expected_classes.size();
   end

endmodule

### sim/tb_network_address_classifier_core.sv
// ----------------------------------------------------------------------------
// Address classifier testbench
// Sends directed corner-case addresses of every kind, then weighted random
// addresses with random idle gaps; the checker predicts and compares each
// response.
// ----------------------------------------------------------------------------
module tb_network_address_classifier_core
   import nac_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_REQUESTS = 600;
   localparam int QUIET_LIMIT     = 2000;
   localparam int DRAIN_CYCLES    = 8;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_addr_kind;
   logic [63:0] req_addr_high;
   logic [63:0] req_addr_low;
   logic        rsp_valid;
   logic [2:0]  rsp_net_class;
   logic        rsp_is_valid;
   logic        rsp_is_routable;
   logic        rsp_was_mapped_v4;
   logic        rsp_is_mesh;
   int          fail_count;
   int          pending_count;
   int          quiet_cycles;
   logic        idle_enable;

   network_address_classifier_core uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_addr_kind     (req_addr_kind),
      .req_addr_high     (req_addr_high),
      .req_addr_low      (req_addr_low),
      .rsp_valid         (rsp_valid),
      .rsp_net_class     (rsp_net_class),
      .rsp_is_valid      (rsp_is_valid),
      .rsp_is_routable   (rsp_is_routable),
      .rsp_was_mapped_v4 (rsp_was_mapped_v4),
      .rsp_is_mesh       (rsp_is_mesh)
   );

   nac_result_checker result_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_addr_kind     (req_addr_kind),
      .req_addr_high     (req_addr_high),
      .req_addr_low      (req_addr_low),
      .rsp_valid         (rsp_valid),
      .rsp_net_class     (rsp_net_class),
      .rsp_is_valid      (rsp_is_valid),
      .rsp_is_routable   (rsp_is_routable),
      .rsp_was_mapped_v4 (rsp_was_mapped_v4),
      .rsp_is_mesh       (rsp_is_mesh),
      .fail_count        (fail_count),
      .pending_count     (pending_count)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // watchdog: cycles with neither a request nor a response taken
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // IPv4 address biased toward the special ranges and their edges
   function automatic logic [31:0] pick_v4();
      logic [7:0] o1;
      logic [7:0] o2;
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return v;
         default: ;
      endcase
      case ($urandom_range(0, 8))
         0: o1 = 8'd0;
         1: o1 = 8'd10;
         2: o1 = 8'd127;
         3: o1 = 8'd169;
         4, 5: o1 = 8'd172;
         6: o1 = 8'd192;
         7: o1 = 8'($urandom_range(239, 255));
         default: o1 = 8'($urandom);
      endcase
      case ($urandom_range(0, 5))
         0: o2 = 8'($urandom_range(16, 31));
         1: o2 = 8'd168;
         2: o2 = 8'd254;
         3: o2 = 8'd15;
         4: o2 = 8'd32;
         default: o2 = 8'($urandom);
      endcase
      return {o1, o2, v[15:0]};
   endfunction

   function automatic void random_address(output logic [1:0] kind, output logic [63:0] hi,
                                          output logic [63:0] lo);
      hi   = rand64();
      lo   = rand64();
      kind = KIND_IPV6;
      case ($urandom_range(0, 19))
         0, 1: kind = KIND_IPV4;
         2, 3, 4: begin
            kind      = KIND_IPV4;
            lo[31:0]  = pick_v4();
         end
         6: hi[63:56] = 8'hFC;
         7: hi[63:56] = 8'hFD;
         8: begin
            hi = 64'hFE80_0000_0000_0000;
            if ($urandom_range(0, 1)) hi[$urandom_range(0, 63)] ^= 1'b1;
         end
         9: hi[63:32] = 32'h2001_0DB8;
         10: hi[63:32] = 32'h2001_0000;
         11: hi[63:36] = 28'h2001_001;
         12, 13: begin
            hi = '0;
            lo = {32'h0000_FFFF, pick_v4()};
         end
         14: begin
            hi        = {56'd0, 8'hFF};
            lo[63:56] = 8'hFF;
            if ($urandom_range(0, 3) == 0) hi[$urandom_range(0, 63)] ^= 1'b1;
         end
         15: begin
            hi = '0;
            lo = 64'($urandom_range(0, 3));
         end
         16: kind = KIND_ONION;
         17: kind = KIND_GARLIC;
         18: begin
            // one bit away from the mapped prefix
            hi = '0;
            lo[63:32] = 32'h0000_FFFF ^ (32'd1 << $urandom_range(0, 31));
         end
         19: hi[63:32] = '0;
         default: ;
      endcase
   endfunction

   task automatic send_request(input logic [1:0] kind, input logic [63:0] hi,
                               input logic [63:0] lo);
      while (idle_enable && $urandom_range(0, 99) < 8) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_addr_kind <= kind;
      req_addr_high <= hi;
      req_addr_low  <= lo;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   initial begin
      logic [1:0]  kind;
      logic [63:0] hi;
      logic [63:0] lo;
      reset         = 1'b1;
      start         = 1'b0;
      req_addr_kind = KIND_IPV4;
      req_addr_high = '0;
      req_addr_low  = '0;
      idle_enable   = 1'b1;
      quiet_cycles  = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // IPv4 edges and ranges; unused bits set where they must be ignored
      send_request(KIND_IPV4, '1, 64'h0);
      send_request(KIND_IPV4, '0, 64'h0000_0000_FFFF_FFFF);
      send_request(KIND_IPV4, '1, 64'hFFFF_FFFF_0808_0808);
      send_request(KIND_IPV4, '0, 64'hF000_0001);
      send_request(KIND_IPV4, '0, 64'h0A01_0203);
      send_request(KIND_IPV4, '0, 64'hC0A8_0101);
      send_request(KIND_IPV4, '0, 64'hAC10_0001);
      send_request(KIND_IPV4, '0, 64'hAC1F_FFFF);
      send_request(KIND_IPV4, '0, 64'hAC20_0001);
      send_request(KIND_IPV4, '0, 64'hA9FE_0304);
      send_request(KIND_IPV4, '0, 64'h7F00_0001);
      send_request(KIND_IPV4, '0, 64'h0001_0203);
      // IPv6: mesh, ULA, link-local, documentation, Teredo, ORCHID, loopback
      send_request(KIND_IPV6, 64'hFC00_0000_0000_0001, '1);
      send_request(KIND_IPV6, 64'hFD12_3456_789A_BCDE, 64'h1);
      send_request(KIND_IPV6, 64'hFE80_0000_0000_0000, 64'h1234_5678_9ABC_DEF0);
      send_request(KIND_IPV6, 64'h2001_0DB8_0000_0000, 64'h1);
      send_request(KIND_IPV6, 64'h2001_0000_4136_E378, 64'h8000_63BF_3FFF_FDD2);
      send_request(KIND_IPV6, 64'h2001_0010_0000_0000, 64'h1);
      send_request(KIND_IPV6, '0, '0);
      send_request(KIND_IPV6, '0, 64'h1);
      // mapped IPv4 and the shifted mapped pattern
      send_request(KIND_IPV6, '0, 64'h0000_FFFF_0102_0304);
      send_request(KIND_IPV6, '0, 64'h0000_FFFF_0000_0000);
      send_request(KIND_IPV6, '0, 64'h0000_FFFF_0A00_0001);
      send_request(KIND_IPV6, 64'h0000_0000_0000_00FF, 64'hFF00_0102_0304_0000);
      send_request(KIND_IPV6, 64'h2606_4700_0000_0000, 64'h6810_85E5);
      send_request(KIND_ONION, rand64(), rand64());
      send_request(KIND_GARLIC, '1, '1);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         idle_enable = !(n >= 250 && n < 400);
         random_address(kind, hi, lo);
         send_request(kind, hi, lo);
      end
      start <= 1'b0;

      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
